/* sv/ftcla_pkg.sv */
// ----------------------------------------------------------------------------
// ftcla_pkg
// Shared types and codes of the force/torque calibration and averaging block.
// ----------------------------------------------------------------------------
`default_nettype none

package ftcla_pkg;

    localparam int AXES   = 6;
    localparam int WORD_W = 32;
    localparam int DIFF_W = 17;
    localparam int ACC_W  = 52;
    localparam int COL_W  = 3;

    localparam logic [1:0] REQ_SAMPLE  = 2'd0;
    localparam logic [1:0] REQ_CAPTURE = 2'd1;
    localparam logic [1:0] REQ_LOAD    = 2'd2;

    localparam logic [1:0] RK_RAW  = 2'd0;
    localparam logic [1:0] RK_SLOW = 2'd1;
    localparam logic [1:0] RK_FAST = 2'd2;

    localparam logic [5:0] IDX_SCALE = 6'd36;
    localparam logic [5:0] IDX_LIMIT = 6'd42;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        logic             mac;
        logic             scale;
        logic             check;
        logic [COL_W-1:0] col;
    } lane_ctrl_t;

    typedef struct packed {
        logic  reject;
        word_t w;
    } lane_stat_t;

endpackage

`default_nettype wire

/* sv/ftcla_lane.sv */
// ----------------------------------------------------------------------------
// ftcla_lane
// One axis lane: holds its matrix row, scale and limit, accumulates the row
// product, scales, rounds and checks the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ftcla_lane
    import ftcla_pkg::*;
#(
    parameter int LANE = 0
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     load_we,
    input  wire logic [5:0]               load_idx,
    input  wire word_t                    load_val,
    input  wire lane_ctrl_t               ctrl,
    input  wire logic signed [DIFF_W-1:0] diff,
    output lane_stat_t                    stat
);

    word_t                    row_reg [AXES];
    word_t                    scale_reg;
    word_t                    limit_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [48:0]       prod;
    logic signed [63:0]       scaled_reg;
    logic                     acc_ok_reg;
    logic signed [63:0]       rounded;
    logic signed [63:0]       w_full;
    logic signed [63:0]       mag;
    logic signed [63:0]       lim_ext;
    logic                     fits;
    lane_stat_t               stat_reg;

    assign prod     = row_reg[ctrl.col] * diff;
    assign acc_next = ((ctrl.col == '0) ? ACC_W'(0) : acc_reg) + ACC_W'(prod);
    assign rounded  = scaled_reg + 64'sd32768;
    assign w_full   = rounded >>> 16;
    assign fits     = (w_full[63:31] == '0) || (w_full[63:31] == '1);
    assign mag      = w_full[63] ? -w_full : w_full;
    assign lim_ext  = {{32{limit_reg[31]}}, limit_reg};

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            for (int c = 0; c < AXES; c++)
            begin
                if (load_idx == 6'(LANE * AXES + c))
                begin
                    row_reg[c] <= load_val;
                end
            end
            if (load_idx == IDX_SCALE + 6'(LANE))
            begin
                scale_reg <= load_val;
            end
            if (load_idx == IDX_LIMIT + 6'(LANE))
            begin
                limit_reg <= load_val;
            end
        end
        if (ctrl.mac)
        begin
            acc_reg <= acc_next;
        end
        if (ctrl.scale)
        begin
            scaled_reg <= $signed(acc_reg[31:0]) * scale_reg;
            acc_ok_reg <= (acc_reg[ACC_W-1:31] == '0) || (acc_reg[ACC_W-1:31] == '1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stat_reg <= '0;
        end
        else if (ctrl.check)
        begin
            stat_reg.w      <= w_full[31:0];
            stat_reg.reject <= !acc_ok_reg || !fits || (mag > lim_ext);
        end
    end

    assign stat = stat_reg;

endmodule

`default_nettype wire

/* sv/ftcla_div.sv */
// ----------------------------------------------------------------------------
// ftcla_div
// Floor division of a signed running sum by the ring length, done as a
// multiplication by a fixed reciprocal taken in 16-bit chunks.
// ----------------------------------------------------------------------------
`default_nettype none

module ftcla_div
    import ftcla_pkg::*;
#(
    parameter int LEN = 2,
    parameter int SW  = 34
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic signed [SW-1:0] value,
    output logic                      done,
    output word_t                     quot
);

    localparam int LW   = $clog2(LEN);
    localparam int MW   = SW + 1;
    localparam int CH_W = 16;
    localparam int NCH  = (MW + CH_W - 1) / CH_W;
    localparam int PADW = NCH * CH_W;
    localparam int PW   = SW + PADW;
    localparam int CW   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam longint unsigned MAGIC =
        ((64'd1 << (SW + LW)) + 64'(LEN) - 64'd1) / 64'(LEN);

    logic                   busy_reg;
    logic                   fin_reg;
    logic                   done_reg;
    logic                   neg_reg;
    logic [SW-1:0]          x_reg;
    logic [PADW-1:0]        m_reg;
    logic [PW-1:0]          acc_reg;
    logic [CW-1:0]          cnt_reg;
    logic [SW+CH_W-1:0]     prod;
    logic [PW-1:0]          acc_next;
    logic [SW-1:0]          q;
    logic [SW-1:0]          res;
    word_t                  quot_reg;

    assign prod     = x_reg * m_reg[PADW-1 -: CH_W];
    assign acc_next = (acc_reg << CH_W) + PW'(prod);
    assign q        = SW'(acc_reg >> (SW + LW));
    assign res      = neg_reg ? SW'(-q) : q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= busy_reg && (cnt_reg == CW'(NCH - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (cnt_reg == CW'(NCH - 1)))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= value[SW-1];
            x_reg   <= value[SW-1] ? (SW'(-value) + SW'(LEN - 1)) : SW'(value);
            m_reg   <= PADW'(MAGIC);
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            m_reg   <= m_reg << CH_W;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (fin_reg)
        begin
            quot_reg <= res[31:0];
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

/* sv/ftcla_avg.sv */
// ----------------------------------------------------------------------------
// ftcla_avg
// Moving average over a ring of wrench rows: running sums per axis and one
// divider lane per axis. Rows not yet written since reset read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ftcla_avg
    import ftcla_pkg::*;
#(
    parameter int LEN = 2
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire word_t held [AXES],
    output logic       done,
    output word_t      avg [AXES]
);

    localparam int SW = WORD_W + 1 + $clog2(LEN);
    localparam int PW = (LEN > 1) ? $clog2(LEN) : 1;
    localparam int RW = AXES * WORD_W;

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_UPD  = 4'b0010,
        A_GO   = 4'b0100,
        A_WAIT = 4'b1000
    } avg_state_t;

    avg_state_t            state_reg;
    logic [RW-1:0]         mem [LEN];
    logic [RW-1:0]         rd_reg;
    logic [RW-1:0]         row;
    logic [PW-1:0]         pos_reg;
    logic                  full_reg;
    logic                  done_reg;
    logic signed [SW-1:0]  sum_reg [AXES];
    logic [AXES-1:0]       div_done;
    word_t                 old_w [AXES];

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            row[i*WORD_W +: WORD_W] = held[i];
            old_w[i] = full_reg ? $signed(rd_reg[i*WORD_W +: WORD_W]) : word_t'(0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == A_IDLE && start)
        begin
            rd_reg <= mem[pos_reg];
        end
        if (state_reg == A_UPD)
        begin
            mem[pos_reg] <= row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            pos_reg   <= '0;
            full_reg  <= 1'b0;
            done_reg  <= 1'b0;
            for (int i = 0; i < AXES; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                A_IDLE:
                begin
                    if (start)
                    begin
                        done_reg  <= 1'b0;
                        state_reg <= A_UPD;
                    end
                end
                A_UPD:
                begin
                    for (int i = 0; i < AXES; i++)
                    begin
                        sum_reg[i] <= sum_reg[i] + SW'(held[i]) - SW'(old_w[i]);
                    end
                    if (pos_reg == PW'(LEN - 1))
                    begin
                        pos_reg  <= '0;
                        full_reg <= 1'b1;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                    state_reg <= A_GO;
                end
                A_GO:
                begin
                    state_reg <= A_WAIT;
                end
                A_WAIT:
                begin
                    if (&div_done)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= A_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    for (genvar g = 0; g < AXES; g++)
    begin : g_div
        ftcla_div #(
            .LEN (LEN),
            .SW  (SW)
        ) u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .start (state_reg == A_GO),
            .value (sum_reg[g]),
            .done  (div_done[g]),
            .quot  (avg[g])
        );
    end

    assign done = done_reg;

endmodule

`default_nettype wire

/* sv/force_torque_calibrate_limit_average.sv */
// ----------------------------------------------------------------------------
// force_torque_calibrate_limit_average
// Six-axis force/torque calibration with overload hold and two moving averages.
// ----------------------------------------------------------------------------
// A sample passes through lane multiply-accumulate, then scaling, checking and
// merging, then ring update and reciprocal division in both averages.
// The three results leave at one per cycle while out_ready is high; a new
// transaction is taken the cycle after the third one is gone.
// Load and capture transactions produce no result. Reset clears bias, held wrench,
// sums and ring pointers; ring rows read as zero until first written.
`default_nettype none

module force_torque_calibrate_limit_average
    import ftcla_pkg::*;
#(
    parameter int SLOW_LEN = 128,
    parameter int FAST_LEN = 2,
    parameter int ADC_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [15:0] adc_ch0,
    input  wire logic [15:0] adc_ch1,
    input  wire logic [15:0] adc_ch2,
    input  wire logic [15:0] adc_ch3,
    input  wire logic [15:0] adc_ch4,
    input  wire logic [15:0] adc_ch5,
    input  wire logic [5:0]  word_index,
    input  wire logic [31:0] word_value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       result_kind,
    output logic [31:0]      force_x,
    output logic [31:0]      force_y,
    output logic [31:0]      force_z,
    output logic [31:0]      torque_x,
    output logic [31:0]      torque_y,
    output logic [31:0]      torque_z,
    output logic             over_limit,
    output logic             last
);

    localparam int AW = (ADC_BITS < 16) ? ADC_BITS : 16;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MAC   = 7'b0000010,
        S_SCALE = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_MERGE = 7'b0010000,
        S_AVG   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t                    state_reg;
    logic [COL_W-1:0]          cnt_reg;
    logic [1:0]                kind_reg;
    logic                      ovr_reg;
    logic                      avg_start_reg;
    logic [15:0]               adc_in [AXES];
    logic signed [15:0]        code_s [AXES];
    logic signed [15:0]        code_reg [AXES];
    logic signed [15:0]        bias_reg [AXES];
    word_t                     held_reg [AXES];
    word_t                     slow_avg [AXES];
    word_t                     fast_avg [AXES];
    word_t                     sel [AXES];
    logic signed [DIFF_W-1:0]  diff;
    lane_ctrl_t                ctrl;
    lane_stat_t                stat [AXES];
    logic [AXES-1:0]           rejects;
    logic                      slow_done;
    logic                      fast_done;
    logic                      in_acc;
    logic                      out_acc;

    assign adc_in[0] = adc_ch0;
    assign adc_in[1] = adc_ch1;
    assign adc_in[2] = adc_ch2;
    assign adc_in[3] = adc_ch3;
    assign adc_in[4] = adc_ch4;
    assign adc_in[5] = adc_ch5;

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            code_s[i]  = 16'($signed(adc_in[i][AW-1:0]));
            rejects[i] = stat[i].reject;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_acc  = out_valid && out_ready;
    assign diff     = DIFF_W'(code_reg[cnt_reg]) - DIFF_W'(bias_reg[cnt_reg]);

    assign ctrl.mac   = (state_reg == S_MAC);
    assign ctrl.scale = (state_reg == S_SCALE);
    assign ctrl.check = (state_reg == S_CHECK);
    assign ctrl.col   = cnt_reg;

    for (genvar g = 0; g < AXES; g++)
    begin : g_lane
        ftcla_lane #(
            .LANE (g)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .load_we  (in_acc && (req_type == REQ_LOAD)),
            .load_idx (word_index),
            .load_val (word_value),
            .ctrl     (ctrl),
            .diff     (diff),
            .stat     (stat[g])
        );
    end

    ftcla_avg #(
        .LEN (SLOW_LEN)
    ) u_slow (
        .clk   (clk),
        .rst_n (rst_n),
        .start (avg_start_reg),
        .held  (held_reg),
        .done  (slow_done),
        .avg   (slow_avg)
    );

    ftcla_avg #(
        .LEN (FAST_LEN)
    ) u_fast (
        .clk   (clk),
        .rst_n (rst_n),
        .start (avg_start_reg),
        .held  (held_reg),
        .done  (fast_done),
        .avg   (fast_avg)
    );

    always_ff @(posedge clk)
    begin
        if (in_acc && (req_type == REQ_SAMPLE))
        begin
            for (int i = 0; i < AXES; i++)
            begin
                code_reg[i] <= code_s[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            kind_reg      <= RK_RAW;
            ovr_reg       <= 1'b0;
            avg_start_reg <= 1'b0;
            for (int i = 0; i < AXES; i++)
            begin
                bias_reg[i] <= '0;
                held_reg[i] <= '0;
            end
        end
        else
        begin
            avg_start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (req_type == REQ_SAMPLE)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= S_MAC;
                        end
                        else if (req_type == REQ_CAPTURE)
                        begin
                            for (int i = 0; i < AXES; i++)
                            begin
                                bias_reg[i] <= code_s[i];
                            end
                        end
                    end
                end
                S_MAC:
                begin
                    if (cnt_reg == COL_W'(AXES - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_SCALE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_SCALE:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    state_reg <= S_MERGE;
                end
                S_MERGE:
                begin
                    ovr_reg <= |rejects;
                    if (!(|rejects))
                    begin
                        for (int i = 0; i < AXES; i++)
                        begin
                            held_reg[i] <= stat[i].w;
                        end
                    end
                    avg_start_reg <= 1'b1;
                    state_reg     <= S_AVG;
                end
                S_AVG:
                begin
                    if (!avg_start_reg && slow_done && fast_done)
                    begin
                        kind_reg  <= RK_RAW;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_acc)
                    begin
                        if (kind_reg == RK_FAST)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            kind_reg <= kind_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            case (kind_reg)
                RK_SLOW: sel[i] = slow_avg[i];
                RK_FAST: sel[i] = fast_avg[i];
                default: sel[i] = held_reg[i];
            endcase
        end
    end

    assign out_valid   = (state_reg == S_OUT);
    assign result_kind = kind_reg;
    assign force_x     = sel[0];
    assign force_y     = sel[1];
    assign force_z     = sel[2];
    assign torque_x    = sel[3];
    assign torque_y    = sel[4];
    assign torque_z    = sel[5];
    assign over_limit  = ovr_reg;
    assign last        = (kind_reg == RK_FAST);

`ifndef SYNTH
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register is not one-hot");

    a_out_avg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (slow_done && fast_done))
        else $error("result presented before averages finished");

    a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (req_type == REQ_SAMPLE)) |=> (state_reg == S_MAC))
        else $error("sample transaction did not start the lanes");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && last) |=> in_ready)
        else $error("block not ready after final result");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_force_torque_calibrate_limit_average.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_force_torque_calibrate_limit_average
// Self-checking testbench for the force/torque calibration and averaging block.
// ----------------------------------------------------------------------------
// Calibration words, bias captures and samples are sent through a bursty
// driver. Each accepted sample is run through a wrench predictor that keeps
// its own calibration, hold and ring state. The three resulting transactions
// are compared in order against the outputs, which are taken under a varying
// stall pattern.
`default_nettype none

module tb_force_torque_calibrate_limit_average
    import ftcla_pkg::*;
();

    localparam int SLOW_N     = 128;
    localparam int FAST_N     = 2;
    localparam int IDLE_LIMIT = 4000;

    typedef struct {
        logic [1:0]  req;
        logic [15:0] ch [AXES];
        logic [5:0]  idx;
        logic [31:0] val;
        bit          drain;
    } sensor_req_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [5:0][31:0]      w;
        logic                  ovr;
        logic                  lst;
    } wrench_out_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [15:0] adc_ch0, adc_ch1, adc_ch2, adc_ch3, adc_ch4, adc_ch5;
    logic [5:0]  word_index;
    logic [31:0] word_value;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  result_kind;
    logic [31:0] force_x, force_y, force_z, torque_x, torque_y, torque_z;
    logic        over_limit;
    logic        last;

    force_torque_calibrate_limit_average uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .adc_ch0(adc_ch0), .adc_ch1(adc_ch1),
        .adc_ch2(adc_ch2), .adc_ch3(adc_ch3), .adc_ch4(adc_ch4),
        .adc_ch5(adc_ch5), .word_index(word_index), .word_value(word_value),
        .out_valid(out_valid), .out_ready(out_ready), .result_kind(result_kind),
        .force_x(force_x), .force_y(force_y), .force_z(force_z),
        .torque_x(torque_x), .torque_y(torque_y), .torque_z(torque_z),
        .over_limit(over_limit), .last(last)
    );

    sensor_req_t pending_reqs [$];
    wrench_out_t expected_wrenches [$];
    sensor_req_t cur_req;

    longint bias_q [AXES];
    longint matrix_q [AXES*AXES];
    longint scale_q [AXES];
    longint limit_q [AXES];
    longint held_q [AXES];
    longint slow_hist [SLOW_N*AXES];
    longint slow_acc [AXES];
    int     slow_ptr;
    longint fast_hist [FAST_N*AXES];
    longint fast_acc [AXES];
    int     fast_ptr;

    int mismatches;
    int idle_cycles;
    int burst_left;
    int gap_left;
    int stall_mode;
    int stall_timer;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic longint floor_div(longint a, longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic bit fits_i32(longint v);
        return v >= -64'sd2147483648 && v <= 64'sd2147483647;
    endfunction

    function automatic wrench_out_t pack_wrench(logic [1:0] kind, longint v [AXES],
                                                bit ovr, bit lst);
        wrench_out_t r;
        r.kind = kind;
        for (int i = 0; i < AXES; i++)
            r.w[i] = v[i][31:0];
        r.ovr = ovr;
        r.lst = lst;
        return r;
    endfunction

    task automatic predict_wrench(sensor_req_t t);
        longint codes [AXES];
        longint w [AXES];
        longint avg [AXES];
        longint acc;
        longint mag;
        bit     ovr;
        ovr = 1'b0;
        for (int i = 0; i < AXES; i++)
            codes[i] = longint'($signed(t.ch[i]));
        if (t.req == REQ_LOAD)
        begin
            if (t.idx < IDX_SCALE)
                matrix_q[t.idx] = longint'($signed(t.val));
            else if (t.idx < IDX_LIMIT)
                scale_q[t.idx - IDX_SCALE] = longint'($signed(t.val));
            else if (t.idx < 6'd48)
                limit_q[t.idx - IDX_LIMIT] = longint'($signed(t.val));
        end
        else if (t.req == REQ_CAPTURE)
        begin
            for (int i = 0; i < AXES; i++)
                bias_q[i] = codes[i];
        end
        else if (t.req == REQ_SAMPLE)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                acc = 0;
                w[i] = 0;
                for (int j = 0; j < AXES; j++)
                    acc += matrix_q[i*AXES+j] * (codes[j] - bias_q[j]);
                if (!fits_i32(acc))
                begin
                    ovr = 1'b1;
                end
                else
                begin
                    w[i] = floor_div(acc * scale_q[i] + 32768, 65536);
                    if (!fits_i32(w[i]))
                    begin
                        ovr = 1'b1;
                    end
                    else
                    begin
                        mag = w[i] < 0 ? -w[i] : w[i];
                        if (mag > limit_q[i])
                            ovr = 1'b1;
                    end
                end
            end
            if (!ovr)
                held_q = w;
            expected_wrenches.push_back(pack_wrench(RK_RAW, held_q, ovr, 1'b0));
            for (int i = 0; i < AXES; i++)
            begin
                slow_acc[i] += held_q[i] - slow_hist[slow_ptr*AXES+i];
                slow_hist[slow_ptr*AXES+i] = held_q[i];
                avg[i] = floor_div(slow_acc[i], SLOW_N);
            end
            slow_ptr = (slow_ptr + 1 >= SLOW_N) ? 0 : slow_ptr + 1;
            expected_wrenches.push_back(pack_wrench(RK_SLOW, avg, ovr, 1'b0));
            for (int i = 0; i < AXES; i++)
            begin
                fast_acc[i] += held_q[i] - fast_hist[fast_ptr*AXES+i];
                fast_hist[fast_ptr*AXES+i] = held_q[i];
                avg[i] = floor_div(fast_acc[i], FAST_N);
            end
            fast_ptr = (fast_ptr + 1 >= FAST_N) ? 0 : fast_ptr + 1;
            expected_wrenches.push_back(pack_wrench(RK_FAST, avg, ovr, 1'b1));
        end
    endtask

    task automatic queue_req(logic [1:0] req, logic [15:0] c0, logic [15:0] c1,
                             logic [15:0] c2, logic [15:0] c3, logic [15:0] c4,
                             logic [15:0] c5, logic [5:0] idx, logic [31:0] val,
                             bit drain);
        sensor_req_t t;
        t.req = req;
        t.ch[0] = c0; t.ch[1] = c1; t.ch[2] = c2;
        t.ch[3] = c3; t.ch[4] = c4; t.ch[5] = c5;
        t.idx = idx;
        t.val = val;
        t.drain = drain;
        pending_reqs.push_back(t);
    endtask

    task automatic queue_load(logic [5:0] idx, logic [31:0] val);
        queue_req(REQ_LOAD, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), idx, val, 1'b0);
    endtask

    task automatic queue_sample(logic [15:0] c0, logic [15:0] c1, logic [15:0] c2,
                                logic [15:0] c3, logic [15:0] c4, logic [15:0] c5,
                                bit drain);
        queue_req(REQ_SAMPLE, c0, c1, c2, c3, c4, c5, 6'($urandom), $urandom, drain);
    endtask

    task automatic queue_random_sample(bit drain);
        queue_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), drain);
    endtask

    function automatic logic [31:0] mild_word(logic [5:0] idx);
        if (idx < IDX_SCALE)
            return 32'($signed($urandom_range(0, 8192)) - 4096);
        else if (idx < IDX_LIMIT)
            return 32'($signed($urandom_range(0, 131072)) - 65536);
        else if ($urandom_range(0, 5) == 0)
            return $urandom_range(0, 32'h00FF_FFFF);
        else
            return 32'h7FFF_FFFF;
    endfunction

    function automatic wrench_out_t observed_wrench();
        wrench_out_t r;
        r.kind = result_kind;
        r.w[0] = force_x;  r.w[1] = force_y;  r.w[2] = force_z;
        r.w[3] = torque_x; r.w[4] = torque_y; r.w[5] = torque_z;
        r.ovr = over_limit;
        r.lst = last;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bit next_valid;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            req_type   <= REQ_SAMPLE;
            adc_ch0    <= '0; adc_ch1 <= '0; adc_ch2 <= '0;
            adc_ch3    <= '0; adc_ch4 <= '0; adc_ch5 <= '0;
            word_index <= '0;
            word_value <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            next_valid = in_valid;
            if (in_valid && in_ready)
            begin
                predict_wrench(cur_req);
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                end
                else if (pending_reqs.size() > 0 &&
                         !(pending_reqs[0].drain && expected_wrenches.size() > 0))
                begin
                    cur_req = pending_reqs.pop_front();
                    req_type   <= cur_req.req;
                    adc_ch0    <= cur_req.ch[0]; adc_ch1 <= cur_req.ch[1];
                    adc_ch2    <= cur_req.ch[2]; adc_ch3 <= cur_req.ch[3];
                    adc_ch4    <= cur_req.ch[4]; adc_ch5 <= cur_req.ch[5];
                    word_index <= cur_req.idx;
                    word_value <= cur_req.val;
                    next_valid = 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(0, 12);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
            in_valid <= next_valid;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        wrench_out_t got;
        wrench_out_t want;
        bit          bad;
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            idle_cycles <= 0;
            stall_mode  <= 0;
            stall_timer <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = observed_wrench();
                if (expected_wrenches.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result transaction: %p", got);
                end
                else
                begin
                    want = expected_wrenches.pop_front();
                    bad = (got.kind !== want.kind) || (got.ovr !== want.ovr) ||
                          (got.lst !== want.lst);
                    for (int i = 0; i < AXES; i++)
                        if (got.w[i] !== want.w[i])
                            bad = 1'b1;
                    if (bad)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %p, actual %p", want, got);
                    end
                end
            end
            if ((out_valid && out_ready) || (in_valid && in_ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("tb_force_torque_calibrate_limit_average: done, errors");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
            if (stall_timer == 0)
            begin
                stall_mode  <= $urandom_range(0, 3);
                stall_timer <= $urandom_range(20, 300);
            end
            else
            begin
                stall_timer <= stall_timer - 1;
            end
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ~out_ready;
            endcase
        end
    end

    initial
    begin
        logic [5:0] idx;
        int         pick;
        mismatches = 0;
        slow_ptr = 0;
        fast_ptr = 0;
        for (int i = 0; i < AXES; i++)
        begin
            bias_q[i] = 0; held_q[i] = 0; slow_acc[i] = 0; fast_acc[i] = 0;
            scale_q[i] = 0; limit_q[i] = 0;
        end
        for (int i = 0; i < AXES*AXES; i++)
            matrix_q[i] = 0;
        for (int i = 0; i < SLOW_N*AXES; i++)
            slow_hist[i] = 0;
        for (int i = 0; i < FAST_N*AXES; i++)
            fast_hist[i] = 0;

        for (int i = 0; i < 48; i++)
            queue_load(6'(i), mild_word(6'(i)));
        queue_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        queue_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        queue_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
        queue_req(REQ_CAPTURE, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                  16'h7FFF, 6'd0, 32'd0, 1'b0);
        queue_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b0);
        queue_req(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  6'd63, 32'hFFFF_FFFF, 1'b0);
        queue_load(6'd63, 32'h8000_0000);
        queue_load(6'd48, 32'hFFFF_FFFF);
        queue_load(IDX_LIMIT + 6'd2, 32'h8000_0000);
        queue_random_sample(1'b0);
        queue_load(IDX_LIMIT + 6'd2, 32'h7FFF_FFFF);
        queue_load(6'd7, 32'h7FFF_FFFF);
        queue_random_sample(1'b0);
        queue_load(6'd7, 32'h0000_0100);
        queue_load(IDX_SCALE + 6'd4, 32'h7FFF_FFFF);
        queue_random_sample(1'b0);
        queue_load(IDX_SCALE + 6'd4, 32'h8000_0000);
        queue_random_sample(1'b0);
        queue_load(IDX_SCALE + 6'd4, 32'h0001_0000);
        queue_req(REQ_CAPTURE, 16'h0123, 16'h0456, 16'h0789, 16'hFEDC, 16'hFBA9,
                  16'hF876, 6'd0, 32'd0, 1'b0);
        queue_sample(16'h0123, 16'h0456, 16'h0789, 16'hFEDC, 16'hFBA9, 16'hF876, 1'b0);

        for (int n = 0; n < 310; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 68)
            begin
                queue_random_sample(n == 140 || n == 300);
            end
            else if (pick < 76)
            begin
                queue_req(REQ_CAPTURE, 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom), 6'($urandom),
                          $urandom, 1'b0);
            end
            else if (pick < 88)
            begin
                idx = 6'($urandom_range(0, 47));
                queue_load(idx, mild_word(idx));
            end
            else if (pick < 92)
            begin
                idx = 6'($urandom_range(0, 47));
                queue_load(idx, $urandom);
                queue_random_sample(1'b0);
                queue_random_sample(1'b0);
                queue_load(idx, mild_word(idx));
            end
            else if (pick < 96)
            begin
                queue_load(6'($urandom_range(48, 63)), $urandom);
            end
            else
            begin
                queue_req(2'd3, 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom), 6'($urandom),
                          $urandom, 1'b0);
            end
        end

        @(posedge rst_n);
        while (pending_reqs.size() > 0 || in_valid)
            @(posedge clk);
        while (expected_wrenches.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("tb_force_torque_calibrate_limit_average: done, clean");
        else
            $display("tb_force_torque_calibrate_limit_average: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
